/* rtl/core/rrd_pkg.sv */
// Shared types and constants for the ring rotation destination block.
package rrd_pkg;

	localparam int MAX_DIM_DEF = 256;
	localparam int STEPS_W     = 32;
	localparam int PER_W       = 11;

	localparam logic [1:0] REG_ROW_COUNT    = 2'd0;
	localparam logic [1:0] REG_COL_COUNT    = 2'd1;
	localparam logic [1:0] REG_ROTATE_STEPS = 2'd2;

	typedef struct packed {
		logic [7:0] src_row;
		logic [7:0] src_col;
	} rrd_in_t;

	typedef struct packed {
		logic [7:0] dst_row;
		logic [7:0] dst_col;
		logic       invalid;
	} rrd_out_t;

	// ring geometry carried down the pipeline with an item
	typedef struct packed {
		logic [7:0]       x;
		logic [7:0]       y;
		logic             bad;
		logic [7:0]       ring;
		logic [7:0]       bot;
		logic [7:0]       rig;
		logic [7:0]       h;
		logic [7:0]       w;
		logic [PER_W-1:0] per;
		logic [PER_W-1:0] p;
	} rrd_ring_t;

endpackage

/* rtl/core/rrd_mod_pipe.sv */
// Bit-per-stage restoring remainder of the step count by the ring perimeter.
module rrd_mod_pipe (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       en,
	input  logic                       vld_in,
	input  rrd_pkg::rrd_ring_t         info_in,
	input  logic [rrd_pkg::STEPS_W-1:0] steps,
	output logic                       vld_out,
	output rrd_pkg::rrd_ring_t         info_out,
	output logic [rrd_pkg::PER_W-1:0]  rem_out
);
	import rrd_pkg::*;

	logic             vld_s  [STEPS_W];
	rrd_ring_t        info_s [STEPS_W];
	logic [PER_W-1:0] rem_s  [STEPS_W];
	logic [PER_W-1:0] rem_d  [STEPS_W];

	// next remainder of each stage: shift in one step bit, subtract if it fits
	always_comb begin
		logic [PER_W-1:0] trial;
		trial    = {{(PER_W-1){1'b0}}, steps[STEPS_W-1]};
		rem_d[0] = (trial >= info_in.per) ? trial - info_in.per : trial;
		for (int k = 1; k < STEPS_W; k++) begin
			trial    = {rem_s[k-1][PER_W-2:0], steps[STEPS_W-1-k]};
			rem_d[k] = (trial >= info_s[k-1].per) ? trial - info_s[k-1].per : trial;
		end
	end

	// valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < STEPS_W; k++) vld_s[k] <= 1'b0;
		end else if (en) begin
			vld_s[0] <= vld_in;
			for (int k = 1; k < STEPS_W; k++) vld_s[k] <= vld_s[k-1];
		end
	end

	// payload
	always_ff @(posedge clk) begin
		if (en) begin
			info_s[0] <= info_in;
			for (int k = 1; k < STEPS_W; k++) info_s[k] <= info_s[k-1];
			for (int k = 0; k < STEPS_W; k++) rem_s[k] <= rem_d[k];
		end
	end

	assign vld_out  = vld_s[STEPS_W-1];
	assign info_out = info_s[STEPS_W-1];
	assign rem_out  = rem_s[STEPS_W-1];

	// remainder stays below the perimeter for a usable ring
	a_rem_lt_per: assert property (@(posedge clk) disable iff (!arst_n)
		(vld_out && !info_out.bad) |-> (rem_out < info_out.per))
		else $error("remainder not below perimeter");

endmodule

/* rtl/core/ring_rotate_destination.sv */
// Top level: destination of a matrix element under counterclockwise ring rotation.
// Takes one coordinate per cycle and returns one result per cycle unless the
// output is stalled; most of the pipeline is the 32-stage remainder unit
// that reduces rotate_steps by the ring perimeter one step bit per stage.
// The whole pipeline holds while a finished result is stalled at the output.
module ring_rotate_destination (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_stall,
	input  rrd_pkg::rrd_in_t            in_data,
	output logic                        out_valid,
	input  logic                        out_stall,
	output rrd_pkg::rrd_out_t           out_data,
	input  logic                        cfg_we,
	input  logic [1:0]                  cfg_idx,
	input  logic [rrd_pkg::STEPS_W-1:0] cfg_wdata
);
	import rrd_pkg::*;

	// largest row or column count in use; larger counts are clamped to it
	localparam int MAX_DIM = MAX_DIM_DEF;

	logic [8:0]         row_count_q;
	logic [8:0]         col_count_q;
	logic [STEPS_W-1:0] steps_q;

	logic adv;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_count_q <= 9'd4;
			col_count_q <= 9'd4;
			steps_q     <= 32'd1;
		end else if (cfg_we) begin
			case (cfg_idx)
				REG_ROW_COUNT:    row_count_q <= cfg_wdata[8:0];
				REG_COL_COUNT:    col_count_q <= cfg_wdata[8:0];
				REG_ROTATE_STEPS: steps_q     <= cfg_wdata;
				default: ;
			endcase
		end
	end

	// whole pipeline moves unless the output holds a stalled result
	assign adv      = !(out_valid && out_stall);
	assign in_stall = !adv;

	// stage 1: clamp counts, range check, ring index
	logic [8:0] n_c, m_c, nx_c, my_c;
	logic [7:0] mn_a, mn_b;
	logic       oor_c;
	logic       vld_s1, oor_s1;
	logic [7:0] x_s1, y_s1, ring_s1;
	logic [8:0] n_s1, m_s1;

	always_comb begin
		n_c   = (32'(row_count_q) > MAX_DIM) ? 9'(MAX_DIM) : row_count_q;
		m_c   = (32'(col_count_q) > MAX_DIM) ? 9'(MAX_DIM) : col_count_q;
		oor_c = ({1'b0, in_data.src_row} >= n_c) || ({1'b0, in_data.src_col} >= m_c);
		nx_c  = n_c - 9'd1 - {1'b0, in_data.src_row};
		my_c  = m_c - 9'd1 - {1'b0, in_data.src_col};
		mn_a  = (in_data.src_row < in_data.src_col) ? in_data.src_row : in_data.src_col;
		mn_b  = (nx_c < my_c) ? nx_c[7:0] : my_c[7:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_s1 <= 1'b0;
		else if (adv) vld_s1 <= in_valid;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			x_s1    <= in_data.src_row;
			y_s1    <= in_data.src_col;
			oor_s1  <= oor_c;
			ring_s1 <= (mn_a < mn_b) ? mn_a : mn_b;
			n_s1    <= n_c;
			m_s1    <= m_c;
		end
	end

	// stage 2: ring corners, perimeter and position along the ring
	rrd_ring_t ring_c;
	logic      vld_s2;
	rrd_ring_t ring_s2;

	always_comb begin
		logic [PER_W-1:0] h11, w11;
		ring_c.x    = x_s1;
		ring_c.y    = y_s1;
		ring_c.ring = ring_s1;
		ring_c.bot  = 8'(n_s1 - 9'd1 - {1'b0, ring_s1});
		ring_c.rig  = 8'(m_s1 - 9'd1 - {1'b0, ring_s1});
		ring_c.h    = ring_c.bot - ring_s1;
		ring_c.w    = ring_c.rig - ring_s1;
		h11         = PER_W'(ring_c.h);
		w11         = PER_W'(ring_c.w);
		ring_c.per  = (h11 + w11) << 1;
		ring_c.bad  = oor_s1 || (ring_c.per == '0);
		if (x_s1 == ring_s1 && y_s1 > ring_s1)
			ring_c.p = (h11 << 1) + w11 + PER_W'(ring_c.rig - y_s1);
		else if (x_s1 == ring_c.bot && y_s1 < ring_c.rig)
			ring_c.p = h11 + PER_W'(y_s1 - ring_s1);
		else if (y_s1 == ring_s1 && x_s1 < ring_c.bot)
			ring_c.p = PER_W'(x_s1 - ring_s1);
		else
			ring_c.p = h11 + w11 + PER_W'(ring_c.bot - x_s1);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_s2 <= 1'b0;
		else if (adv) vld_s2 <= vld_s1;
	end

	always_ff @(posedge clk) begin
		if (adv) ring_s2 <= ring_c;
	end

	// steps modulo perimeter
	logic             vld_m;
	rrd_ring_t        ring_m;
	logic [PER_W-1:0] rem_m;

	rrd_mod_pipe u_mod (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (adv),
		.vld_in   (vld_s2),
		.info_in  (ring_s2),
		.steps    (steps_q),
		.vld_out  (vld_m),
		.info_out (ring_m),
		.rem_out  (rem_m)
	);

	// stage q: new position along the ring
	logic [PER_W-1:0] qsum_c;
	logic             vld_sq;
	rrd_ring_t        ring_sq;
	logic [PER_W-1:0] q_sq;

	assign qsum_c = ring_m.p + rem_m;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_sq <= 1'b0;
		else if (adv) vld_sq <= vld_m;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			ring_sq <= ring_m;
			q_sq    <= (qsum_c >= ring_m.per) ? qsum_c - ring_m.per : qsum_c;
		end
	end

	// output stage: map position back to row and column
	rrd_out_t res_c;

	always_comb begin
		logic [PER_W-1:0] h11, w11;
		h11 = PER_W'(ring_sq.h);
		w11 = PER_W'(ring_sq.w);
		res_c.invalid = ring_sq.bad;
		if (ring_sq.bad) begin
			res_c.dst_row = ring_sq.x;
			res_c.dst_col = ring_sq.y;
		end else if (q_sq < h11) begin
			res_c.dst_row = ring_sq.ring + q_sq[7:0];
			res_c.dst_col = ring_sq.ring;
		end else if (q_sq < h11 + w11) begin
			res_c.dst_row = ring_sq.bot;
			res_c.dst_col = 8'(PER_W'(ring_sq.ring) + q_sq - h11);
		end else if (q_sq < (h11 << 1) + w11) begin
			res_c.dst_row = 8'(PER_W'(ring_sq.bot) - (q_sq - h11 - w11));
			res_c.dst_col = ring_sq.rig;
		end else begin
			res_c.dst_row = ring_sq.ring;
			res_c.dst_col = 8'(PER_W'(ring_sq.rig) - (q_sq - (h11 << 1) - w11));
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) out_valid <= 1'b0;
		else if (adv) out_valid <= vld_sq;
	end

	always_ff @(posedge clk) begin
		if (adv) out_data <= res_c;
	end

	// input is held off only by a stalled result at the output
	a_stall_src: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> (out_valid && out_stall))
		else $error("input stalled without output backpressure");

	// wrapped position lies on the ring
	a_q_lt_per: assert property (@(posedge clk) disable iff (!arst_n)
		(vld_sq && !ring_sq.bad) |-> (q_sq < ring_sq.per))
		else $error("ring position beyond perimeter");

	// a held result is kept while stalled
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_stall) |=> (out_valid && $stable(out_data)))
		else $error("stalled result changed");

endmodule
